// ===== sv/ochmu_pkg.sv =====
// shared types and constants for the occupancy cell hit/miss update block
// no dependencies; imported by ochmu_div, the top module and the testbench
package ochmu_pkg;

  localparam int DEFAULT_MAX_COLS    = 256;
  localparam int DEFAULT_MAX_ROWS    = 256;
  localparam int DEFAULT_COUNT_CLAMP = 20;

  localparam int COORD_W    = 20;  // world coordinates and grid extents
  localparam int TILE_W     = 13;  // tile size register
  localparam int DIM_W      = 9;   // column, row and threshold registers
  localparam int TOTAL_W    = 32;  // global counters
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int Q8_SHIFT   = 8;   // threshold is in units of 1/256

  localparam logic [TILE_W-1:0] TILE_RESET   = TILE_W'(100);
  localparam logic [DIM_W-1:0]  THRESH_RESET = DIM_W'(128);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_LEFT   = 3'd0,
    REG_GRID_TOP    = 3'd1,
    REG_GRID_WIDTH  = 3'd2,
    REG_GRID_HEIGHT = 3'd3,
    REG_TILE_SIZE   = 3'd4,
    REG_GRID_COLS   = 3'd5,
    REG_GRID_ROWS   = 3'd6,
    REG_OCC_THRESH  = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_IDX,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic                      func;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic               cell_found;
    logic               cell_occupied;
    logic               cell_flipped;
    logic [TOTAL_W-1:0] updated_total;
    logic [TOTAL_W-1:0] flipped_total;
  } out_item_t;

endpackage

// ===== sv/ochmu_ram.sv =====
// generic simple dual port ram, one write and one registered read port
// no dependencies
module ochmu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/ochmu_div.sv =====
// restoring divider, one quotient bit per cycle, quotient rounded to
// nearest with ties to even; depends on ochmu_pkg
module ochmu_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ochmu_pkg::COORD_W-1:0] dividend,
  input  logic [ochmu_pkg::TILE_W-1:0]  divisor,
  output logic                         done,
  output logic [ochmu_pkg::COORD_W-1:0] quot
);
  import ochmu_pkg::*;

  localparam int CNT_W = $clog2(COORD_W + 1);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [TILE_W-1:0]  rem_r, rem_nxt;
  logic [COORD_W-1:0] quo_r, quo_nxt;
  logic [TILE_W-1:0]  den_r, den_nxt;
  logic [TILE_W:0]    trial;
  logic               ge;
  logic [TILE_W+1:0]  rem2;
  logic               round_up;

  assign trial = {rem_r, quo_r[COORD_W-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      den_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? TILE_W'(trial - {1'b0, den_r}) : TILE_W'(trial);
      quo_nxt = {quo_r[COORD_W-2:0], ge};
      cnt_nxt = CNT_W'(cnt_r + 1'b1);
      if (cnt_r == CNT_W'(COORD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  // ties go to the even quotient
  assign rem2     = {1'b0, rem_r, 1'b0};
  assign round_up = (rem2 > {2'b00, den_r}) || ((rem2 == {2'b00, den_r}) && quo_r[0]);
  assign quot     = COORD_W'(quo_r + {{(COORD_W-1){1'b0}}, round_up});
  assign done     = done_r;

endmodule

// ===== sv/occupancy_cell_hit_miss_update.sv =====
// occupancy grid cell update from one hit or miss observation per beat.
// after reset the cell store is swept once, one cell per cycle, through all
// MAX_COLS*MAX_ROWS cells (65536 with the defaults); no input beat is taken
// during that sweep, configuration writes are. each item then goes through
// these steps before the next beat is accepted: the beat is accepted, the
// restoring dividers turn both offsets into column and row indices in parallel
// (20 quotient bits, one per cycle, then rounded to nearest), the cell address
// is formed and the store read, and the cell word is modified and written back
// and the result register loaded, held for as long as the previous result
// still waits. one item is in flight at a time; the result register lets the
// next beat be accepted while a result still waits.
// depends on ochmu_pkg, ochmu_div and ochmu_ram
module occupancy_cell_hit_miss_update #(
  parameter int MAX_COLS    = ochmu_pkg::DEFAULT_MAX_COLS,
  parameter int MAX_ROWS    = ochmu_pkg::DEFAULT_MAX_ROWS,
  parameter int COUNT_CLAMP = ochmu_pkg::DEFAULT_COUNT_CLAMP
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ochmu_pkg::in_item_t             in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ochmu_pkg::out_item_t            out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ochmu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ochmu_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ochmu_pkg::*;

  // store geometry and word layout: {free, misses, hits}
  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(COUNT_CLAMP + 1);
  localparam int WW    = 2 * CW + 1;
  localparam int PW    = DIM_W + CW + 2;  // threshold times total count

  // configuration registers
  logic signed [COORD_W-1:0] grid_left_r;
  logic signed [COORD_W-1:0] grid_top_r;
  logic [COORD_W-1:0]        grid_width_r;
  logic [COORD_W-1:0]        grid_height_r;
  logic [TILE_W-1:0]         tile_size_r;
  logic [DIM_W-1:0]          grid_cols_r;
  logic [DIM_W-1:0]          grid_rows_r;
  logic [DIM_W-1:0]          occ_thresh_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_left_r   <= '0;
      grid_top_r    <= '0;
      grid_width_r  <= '0;
      grid_height_r <= '0;
      tile_size_r   <= TILE_RESET;
      grid_cols_r   <= '0;
      grid_rows_r   <= '0;
      occ_thresh_r  <= THRESH_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GRID_LEFT:   grid_left_r   <= cfg_data;
        REG_GRID_TOP:    grid_top_r    <= cfg_data;
        REG_GRID_WIDTH:  grid_width_r  <= cfg_data;
        REG_GRID_HEIGHT: grid_height_r <= cfg_data;
        REG_TILE_SIZE:   tile_size_r   <= cfg_data[TILE_W-1:0];
        REG_GRID_COLS:   grid_cols_r   <= cfg_data[DIM_W-1:0];
        REG_GRID_ROWS:   grid_rows_r   <= cfg_data[DIM_W-1:0];
        REG_OCC_THRESH:  occ_thresh_r  <= cfg_data[DIM_W-1:0];
      endcase
    end
  end

  // state machine and control
  state_t state_r, state_nxt;

  logic          in_acc;
  logic          div_start;
  logic          div_done;
  logic          slot_free;
  logic          ram_re;
  logic          ram_we;
  logic          commit;
  logic          clr_last;
  logic [AW-1:0] clr_addr_r;
  logic          out_valid_r;

  assign in_acc    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign clr_last  = clr_addr_r == AW'(DEPTH - 1);

  // item registers
  logic               func_r;
  logic               in_rect_r;
  logic [COORD_W-1:0] col_r;
  logic [COORD_W-1:0] row_r;
  logic               found_r, found_nxt;
  logic [AW-1:0]      addr_r, addr_nxt;
  out_item_t          out_data_r;
  logic [TOTAL_W-1:0] upd_total_r, upd_total_nxt;
  logic [TOTAL_W-1:0] flip_total_r, flip_total_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_acc) state_nxt = ST_DIV;
      ST_DIV:   if (div_done) state_nxt = ST_IDX;
      ST_IDX:   state_nxt = ST_FIN;
      ST_FIN:   if (slot_free) state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    commit    = 1'b0;
    unique case (state_r)
      ST_CLEAR: ram_we = 1'b1;
      ST_IDLE: begin
        in_ready  = 1'b1;
        div_start = in_valid;
      end
      ST_DIV:   ;
      ST_IDX:   ram_re = found_nxt;
      ST_FIN: begin
        commit = slot_free;
        ram_we = slot_free && found_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= AW'(clr_addr_r + 1'b1);
      end
    end
  end

  // offsets from the grid corner; edges of the rectangle count as inside
  logic signed [COORD_W:0] dx;
  logic signed [COORD_W:0] dz;
  logic                    in_rect;
  logic [TILE_W-1:0]       tile_eff;

  assign dx       = {in_data.point_x[COORD_W-1], in_data.point_x}
                  - {grid_left_r[COORD_W-1], grid_left_r};
  assign dz       = {in_data.point_z[COORD_W-1], in_data.point_z}
                  - {grid_top_r[COORD_W-1], grid_top_r};
  assign in_rect  = !dx[COORD_W] && (dx[COORD_W-1:0] <= grid_width_r)
                 && !dz[COORD_W] && (dz[COORD_W-1:0] <= grid_height_r);
  // a zero tile size divides by one
  assign tile_eff = (tile_size_r == '0) ? TILE_W'(1) : tile_size_r;

  logic               col_done;
  logic               row_done;
  logic [COORD_W-1:0] col_q;
  logic [COORD_W-1:0] row_q;

  ochmu_div u_div_col (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dx[COORD_W-1:0]),
    .divisor  (tile_eff),
    .done     (col_done),
    .quot     (col_q)
  );

  ochmu_div u_div_row (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dz[COORD_W-1:0]),
    .divisor  (tile_eff),
    .done     (row_done),
    .quot     (row_q)
  );

  assign div_done = col_done && row_done;

  // cell lookup: bounded by both the configured and the built grid size
  assign found_nxt = in_rect_r
                  && (col_r < {{(COORD_W-DIM_W){1'b0}}, grid_cols_r})
                  && (row_r < {{(COORD_W-DIM_W){1'b0}}, grid_rows_r})
                  && (col_r < COORD_W'(MAX_COLS))
                  && (row_r < COORD_W'(MAX_ROWS));
  assign addr_nxt  = AW'(row_r * MAX_COLS + col_r);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r    <= in_data.func;
      in_rect_r <= in_rect;
    end
    if (state_r == ST_DIV && div_done) begin
      col_r <= col_q;
      row_r <= row_q;
    end
    if (state_r == ST_IDX) begin
      found_r <= found_nxt;
      addr_r  <= addr_nxt;
    end
  end

  // cell store
  logic [WW-1:0] ram_rdata;
  logic [WW-1:0] ram_wdata;
  logic [AW-1:0] ram_waddr;

  ochmu_ram #(
    .WIDTH (WW),
    .DEPTH (DEPTH)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr_nxt),
    .rdata (ram_rdata)
  );

  // read-modify-write of the cell word
  logic [CW-1:0] hits_old;
  logic [CW-1:0] miss_old;
  logic          was_free;
  logic [CW:0]   hits_inc;
  logic [CW:0]   miss_inc;
  logic [CW+1:0] total;
  logic [PW-1:0] lhs;
  logic [PW-1:0] rhs;
  logic          ratio_ge;
  logic          now_free;
  logic [CW-1:0] hits_new;
  logic [CW-1:0] miss_new;
  logic          flipped;

  assign hits_old = ram_rdata[CW-1:0];
  assign miss_old = ram_rdata[2*CW-1:CW];
  assign was_free = ram_rdata[WW-1];
  assign hits_inc = {1'b0, hits_old} + {{CW{1'b0}}, func_r};
  assign miss_inc = {1'b0, miss_old} + {{CW{1'b0}}, !func_r};
  assign total    = {1'b0, hits_inc} + {1'b0, miss_inc};
  // hits/total against thr/256, cross multiplied
  assign lhs      = PW'({hits_inc, {Q8_SHIFT{1'b0}}});
  assign rhs      = PW'({{(PW-DIM_W){1'b0}}, occ_thresh_r} * {{(PW-CW-2){1'b0}}, total});
  assign ratio_ge = lhs >= rhs;

  always_comb begin
    now_free = was_free;
    hits_new = hits_old;
    miss_new = miss_old;
    if (func_r) begin
      if (ratio_ge) now_free = 1'b0;
      hits_new = (hits_inc > (CW+1)'(COUNT_CLAMP)) ? CW'(COUNT_CLAMP) : CW'(hits_inc);
    end else begin
      if (!ratio_ge) now_free = 1'b1;
      miss_new = (miss_inc > (CW+1)'(COUNT_CLAMP)) ? CW'(COUNT_CLAMP) : CW'(miss_inc);
    end
  end

  assign flipped   = now_free != was_free;
  // the sweep writes free cells with zero counts
  assign ram_waddr = (state_r == ST_CLEAR) ? clr_addr_r : addr_r;
  assign ram_wdata = (state_r == ST_CLEAR) ? {1'b1, {(2*CW){1'b0}}}
                                           : {now_free, miss_new, hits_new};

  // saturating global counters
  always_comb begin
    upd_total_nxt  = upd_total_r;
    flip_total_nxt = flip_total_r;
    if (found_r) begin
      if (upd_total_r != '1) upd_total_nxt = TOTAL_W'(upd_total_r + 1'b1);
      if (flipped && flip_total_r != '1) flip_total_nxt = TOTAL_W'(flip_total_r + 1'b1);
    end
  end

  // result register, freed when the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      upd_total_r  <= '0;
      flip_total_r <= '0;
    end else begin
      if (commit) begin
        out_valid_r  <= 1'b1;
        upd_total_r  <= upd_total_nxt;
        flip_total_r <= flip_total_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (commit) begin
      out_data_r.cell_found    <= found_r;
      out_data_r.cell_occupied <= found_r && !now_free;
      out_data_r.cell_flipped  <= found_r && flipped;
      out_data_r.updated_total <= upd_total_nxt;
      out_data_r.flipped_total <= flip_total_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== dv/occupancy_cell_hit_miss_update_tb.sv =====
// self-checking testbench for the occupancy cell hit/miss update block
// holds its own grid predictor in a small scoreboard class; depends on ochmu_pkg
// and on the occupancy_cell_hit_miss_update rtl
`timescale 1ns / 100ps

class occupancy_scoreboard;
  // shadow of the cell store
  logic [4:0] hit_cnt  [ochmu_pkg::DEFAULT_MAX_COLS * ochmu_pkg::DEFAULT_MAX_ROWS];
  logic [4:0] miss_cnt [ochmu_pkg::DEFAULT_MAX_COLS * ochmu_pkg::DEFAULT_MAX_ROWS];
  bit         free_mark[ochmu_pkg::DEFAULT_MAX_COLS * ochmu_pkg::DEFAULT_MAX_ROWS];
  logic [31:0] n_updates;
  logic [31:0] n_flips;

  // shadow of the registers
  logic signed [19:0] left_x;
  logic signed [19:0] top_z;
  logic [19:0] span_x;
  logic [19:0] span_z;
  logic [12:0] tile;
  logic [8:0]  cols;
  logic [8:0]  rows;
  logic [8:0]  thresh;

  ochmu_pkg::out_item_t expected_updates[$];
  int mismatches;
  int n_obs;
  int n_found;
  int n_flipped;

  function new();
    for (int i = 0; i < $size(hit_cnt); i++) begin
      hit_cnt[i]   = '0;
      miss_cnt[i]  = '0;
      free_mark[i] = 1'b1;
    end
    n_updates  = '0;
    n_flips    = '0;
    left_x     = '0;
    top_z      = '0;
    span_x     = '0;
    span_z     = '0;
    tile       = ochmu_pkg::TILE_RESET;
    cols       = '0;
    rows       = '0;
    thresh     = ochmu_pkg::THRESH_RESET;
    mismatches = 0;
    n_obs      = 0;
    n_found    = 0;
    n_flipped  = 0;
  endfunction

  function void set_register(ochmu_pkg::cfg_reg_t idx, logic [19:0] v);
    case (idx)
      ochmu_pkg::REG_GRID_LEFT:   left_x = v;
      ochmu_pkg::REG_GRID_TOP:    top_z  = v;
      ochmu_pkg::REG_GRID_WIDTH:  span_x = v;
      ochmu_pkg::REG_GRID_HEIGHT: span_z = v;
      ochmu_pkg::REG_TILE_SIZE:   tile   = v[12:0];
      ochmu_pkg::REG_GRID_COLS:   cols   = v[8:0];
      ochmu_pkg::REG_GRID_ROWS:   rows   = v[8:0];
      ochmu_pkg::REG_OCC_THRESH:  thresh = v[8:0];
      default: ;
    endcase
  endfunction

  // nearest integer quotient, ties to even
  function automatic longint round_half_even(longint num, longint den);
    longint q;
    longint r;
    q = num / den;
    r = num % den;
    if (2 * r > den || (2 * r == den && q[0])) q++;
    return q;
  endfunction

  function void note_observation(ochmu_pkg::in_item_t it);
    longint px, pz, lo_x, lo_z, hi_x, hi_z, t, col, row;
    int addr, h, m, lhs, rhs;
    bit was_free, now_free;
    ochmu_pkg::out_item_t r;
    px   = $signed(it.point_x);
    pz   = $signed(it.point_z);
    lo_x = left_x;
    lo_z = top_z;
    hi_x = lo_x + longint'(span_x);
    hi_z = lo_z + longint'(span_z);
    t    = (tile == 0) ? 1 : longint'(tile);
    r    = '0;
    n_obs++;
    if (px >= lo_x && px <= hi_x && pz >= lo_z && pz <= hi_z) begin
      col = round_half_even(px - lo_x, t);
      row = round_half_even(pz - lo_z, t);
      if (col < longint'(cols) && row < longint'(rows) &&
          col < ochmu_pkg::DEFAULT_MAX_COLS && row < ochmu_pkg::DEFAULT_MAX_ROWS) begin
        addr     = int'(row) * ochmu_pkg::DEFAULT_MAX_COLS + int'(col);
        h        = hit_cnt[addr];
        m        = miss_cnt[addr];
        was_free = free_mark[addr];
        now_free = was_free;
        if (it.func) h++;
        else m++;
        lhs = h * 256;
        rhs = int'(thresh) * (h + m);
        if (it.func) begin
          if (lhs >= rhs) now_free = 1'b0;
          if (h > ochmu_pkg::DEFAULT_COUNT_CLAMP) h = ochmu_pkg::DEFAULT_COUNT_CLAMP;
        end else begin
          if (lhs < rhs) now_free = 1'b1;
          if (m > ochmu_pkg::DEFAULT_COUNT_CLAMP) m = ochmu_pkg::DEFAULT_COUNT_CLAMP;
        end
        hit_cnt[addr]   = h[4:0];
        miss_cnt[addr]  = m[4:0];
        free_mark[addr] = now_free;
        r.cell_found    = 1'b1;
        r.cell_occupied = !now_free;
        r.cell_flipped  = (now_free != was_free);
        if (r.cell_flipped) begin
          n_flipped++;
          if (n_flips != '1) n_flips++;
        end
        if (n_updates != '1) n_updates++;
        n_found++;
      end
    end
    r.updated_total = n_updates;
    r.flipped_total = n_flips;
    expected_updates = {expected_updates, r};
  endfunction

  function void check_update(ochmu_pkg::out_item_t got);
    ochmu_pkg::out_item_t want;
    if (expected_updates.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result beat %h", $time, got);
      return;
    end
    want = expected_updates.pop_front();
    if (got.cell_found !== want.cell_found || got.cell_occupied !== want.cell_occupied ||
        got.cell_flipped !== want.cell_flipped || got.updated_total !== want.updated_total ||
        got.flipped_total !== want.flipped_total) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: mismatch found/occ/flip/upd/flips exp %b/%b/%b/%0d/%0d got %b/%b/%b/%0d/%0d",
                 $time, want.cell_found, want.cell_occupied, want.cell_flipped,
                 want.updated_total, want.flipped_total, got.cell_found, got.cell_occupied,
                 got.cell_flipped, got.updated_total, got.flipped_total);
    end
  endfunction

  function int owed_count();
    return expected_updates.size();
  endfunction
endclass

module occupancy_cell_hit_miss_update_tb;
  import ochmu_pkg::*;

  // the limit is several times the slowest correct run, the store sweep plus
  // all observations
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE      = 64;     // latency allowance once nothing is owed
  localparam int RAND_PHASES = 6;
  localparam int PHASE_ITEMS = 180;
  localparam bit OBS_MISS    = 1'b0;
  localparam bit OBS_HIT     = 1'b1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  occupancy_scoreboard sb = new();

  bit idle_on = 1'b1;       // random gaps and stalls allowed
  int hit_pct = 50;         // share of hits among random observations
  int stall_left = 0;
  int cycles = 0;
  int n_settings = 0;

  // current grid, kept here so random points can be aimed at cells
  longint g_left, g_top, g_width, g_height, g_tile;
  int g_cols, g_rows;

  occupancy_cell_hit_miss_update DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycles, sb.owed_count());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: check every accepted beat, then decide ready for the next edge.
  // stalls come in bursts of random length
  always @(posedge clk) begin
    if (out_valid && out_ready) sb.check_update(out_data);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // one observation beat; valid stays high across back-to-back beats, an idle
  // burst drops it first. returns at the accepting edge
  task automatic send_obs(bit f, longint x, longint z);
    in_item_t it;
    it.func    = f;
    it.point_x = x[19:0];
    it.point_z = z[19:0];
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_observation(it);
  endtask

  // sender holds off until every owed result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.owed_count() != 0);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [19:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, v);
  endtask

  // all eight registers, only while nothing is in flight
  task automatic program_grid(longint left, longint top, longint width, longint height,
                              int tile, int cols, int rows, int thresh);
    write_reg(REG_GRID_LEFT,   left[19:0]);
    write_reg(REG_GRID_TOP,    top[19:0]);
    write_reg(REG_GRID_WIDTH,  width[19:0]);
    write_reg(REG_GRID_HEIGHT, height[19:0]);
    write_reg(REG_TILE_SIZE,   20'(tile));
    write_reg(REG_GRID_COLS,   20'(cols));
    write_reg(REG_GRID_ROWS,   20'(rows));
    write_reg(REG_OCC_THRESH,  20'(thresh));
    cfg_valid <= 1'b0;
    g_left   = left;
    g_top    = top;
    g_width  = width;
    g_height = height;
    g_tile   = (tile == 0) ? 1 : tile;
    g_cols   = cols;
    g_rows   = rows;
    n_settings++;
  endtask

  // random grid: mostly a handful of cells so they get revisited, clamp and flip;
  // sometimes counts beyond the store, zero or huge tiles, odd thresholds
  task automatic random_grid();
    int tile, cols, rows, thresh, t, ccap;
    longint width, height, left, top;
    case ($urandom_range(0, 9))
      0:       tile = 0;
      1:       tile = 8191;
      2:       tile = 4096;
      3, 4:    tile = $urandom_range(1, 8);
      default: tile = $urandom_range(1, 600);
    endcase
    case ($urandom_range(0, 7))
      0:       cols = $urandom_range(256, 511);
      1:       cols = 0;
      default: cols = $urandom_range(1, 8);
    endcase
    case ($urandom_range(0, 7))
      0:       rows = $urandom_range(256, 511);
      1:       rows = 0;
      default: rows = $urandom_range(1, 8);
    endcase
    case ($urandom_range(0, 6))
      0:       thresh = 0;
      1:       thresh = 256;
      2:       thresh = $urandom_range(257, 511);
      3:       thresh = 128;
      default: thresh = $urandom_range(0, 256);
    endcase
    t      = (tile == 0) ? 1 : tile;
    ccap   = (cols > 260) ? 260 : cols;
    width  = longint'(ccap) * t + $urandom_range(0, t);
    ccap   = (rows > 260) ? 260 : rows;
    height = longint'(ccap) * t + $urandom_range(0, t);
    if (width > 1048575) width = 1048575;
    if (height > 1048575) height = 1048575;
    left = longint'($urandom_range(0, 1048575 - width)) - 524288;
    top  = longint'($urandom_range(0, 1048575 - height)) - 524288;
    program_grid(left, top, width, height, tile, cols, rows, thresh);
    hit_pct = $urandom_range(20, 80);
  endtask

  // one coordinate: mostly aimed near a cell center (ties included), some on or
  // just past the rectangle edges, the rest anywhere
  function automatic longint pick_coord(longint base, longint ext, int count);
    int kind, hi, c;
    longint d;
    kind = $urandom_range(0, 99);
    if (kind < 80) begin
      hi = (count > 256) ? 256 : count;
      c  = ($urandom_range(0, 1) == 0) ? $urandom_range(0, (hi < 2) ? hi : 2)
                                       : $urandom_range(0, hi);
      d  = longint'(c) * g_tile + longint'($urandom_range(0, g_tile)) - g_tile / 2;
      if (d < 0) d = 0;
      if (d > ext) d = ext;
      return base + d;
    end else if (kind < 88) begin
      case ($urandom_range(0, 3))
        0:       return base - 1;
        1:       return base;
        2:       return base + ext;
        default: return base + ext + 1;
      endcase
    end
    return longint'($urandom_range(0, 1048575)) - 524288;
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: zero-size rectangle at the origin, no columns
    send_obs(OBS_HIT,  0, 0);
    send_obs(OBS_MISS, 1, 0);
    drain();

    // 11x9 grid of 100-unit tiles, half threshold
    program_grid(-1000, 500, 1000, 800, 100, 11, 9, 128);
    send_obs(OBS_HIT,  -1000, 500);    // corner cell turns occupied
    send_obs(OBS_MISS, -1000, 500);    // ratio exactly at threshold, stays
    send_obs(OBS_MISS, -1000, 500);    // drops below, freed again
    send_obs(OBS_HIT,  0, 1300);       // far corner, on the edge
    send_obs(OBS_MISS, -1001, 500);    // one past each edge
    send_obs(OBS_MISS, 1, 500);
    send_obs(OBS_HIT,  -1000, 499);
    send_obs(OBS_HIT,  -1000, 1301);
    send_obs(OBS_HIT,  -850, 500);     // 1.5 rounds up to even
    send_obs(OBS_HIT,  -750, 550);     // 2.5 and 0.5 round down to even
    send_obs(OBS_MISS, -949, 651);
    send_obs(OBS_HIT,  -524288, 524287);
    send_obs(OBS_HIT,  524287, -524288);
    drain();

    // widest rectangle, counts equal to the store size, zero threshold
    program_grid(-524288, -524288, 1048575, 1048575, 4096, 256, 256, 0);
    send_obs(OBS_HIT,  -524288, -524288);
    send_obs(OBS_MISS, -524288, -524288);
    send_obs(OBS_HIT,  524287, 524287);  // rounds to column 256, past the store
    send_obs(OBS_MISS, 0, 0);
    drain();

    // zero tile acts as one, counts beyond the store, threshold past one
    program_grid(-5, -5, 300, 40, 0, 511, 300, 511);
    send_obs(OBS_HIT,  250, -5);
    send_obs(OBS_HIT,  251, -5);
    send_obs(OBS_MISS, -5, -2);
    send_obs(OBS_HIT,  -5, 35);
    drain();

    // random grids; the last one runs without gaps or stalls
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      idle_on = (ph < RAND_PHASES - 1) ? ($urandom_range(0, 3) != 0) : 1'b0;
      random_grid();
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 2 && i == PHASE_ITEMS / 2) drain();
        send_obs($urandom_range(0, 99) < hit_pct,
                 pick_coord(g_left, g_width, g_cols),
                 pick_coord(g_top, g_height, g_rows));
      end
      drain();
    end

    repeat (SETTLE) @(posedge clk);
    $display("%0d observations over %0d grid settings: %0d cell updates, %0d state flips",
             sb.n_obs, n_settings, sb.n_found, sb.n_flipped);
    if (sb.mismatches == 0 && sb.owed_count() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results never arrived", sb.mismatches, sb.owed_count());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/ochmu_pkg.sv
sv/ochmu_ram.sv
sv/ochmu_div.sv
sv/occupancy_cell_hit_miss_update.sv
dv/occupancy_cell_hit_miss_update_tb.sv
